// ----- sv/act_pkg.sv -----
`default_nettype none

package act_pkg;

  localparam int SIDE_W  = 2;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int POS_W   = 48;
  localparam int FEE_W   = 48;
  localparam int MONEY_W = 64;

  // serial unit accumulator: holds mag + qty and the running partial product
  localparam int ACC_W  = POS_W + 1;
  localparam int STEP_W = $clog2(PRICE_W);

  localparam logic [SIDE_W-1:0] SIDE_BUY  = 2'b01;
  localparam logic [SIDE_W-1:0] SIDE_SELL = 2'b11;

  localparam logic signed [POS_W-1:0]   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [MONEY_W-1:0] MONEY_MAX = {1'b0, {(MONEY_W-1){1'b1}}};
  localparam logic signed [MONEY_W-1:0] MONEY_MIN = {1'b1, {(MONEY_W-1){1'b0}}};

  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [PRICE_W-1:0] price_t;

endpackage

`default_nettype wire

// ----- sv/act_smac.sv -----
`default_nettype none

// bit-serial sum of two products: mcand_a * mplier_a + mcand_b * mplier_b
module act_smac import act_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [POS_W-1:0] mcand_a,
  input  price_t           mplier_a,
  input  logic [QTY_W-1:0] mcand_b,
  input  price_t           mplier_b,
  output logic             done,
  output acc_t             prod_hi,
  output price_t           prod_lo
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [POS_W-1:0]  ma_r;
  logic [QTY_W-1:0]  mb_r;
  price_t            xa_r;
  price_t            xb_r;
  acc_t              hi_r;
  price_t            lo_r;
  logic [ACC_W:0]    step_sum;

  // one multiplier bit of each operand per cycle, low bits shift into lo_r
  assign step_sum = {1'b0, hi_r}
                  + (xa_r[0] ? (ACC_W+1)'(ma_r) : '0)
                  + (xb_r[0] ? (ACC_W+1)'(mb_r) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        ma_r   <= mcand_a;
        mb_r   <= mcand_b;
        xa_r   <= mplier_a;
        xb_r   <= mplier_b;
        hi_r   <= '0;
        lo_r   <= '0;
      end else if (busy_r) begin
        hi_r  <= step_sum[ACC_W:1];
        lo_r  <= {step_sum[0], lo_r[PRICE_W-1:1]};
        xa_r  <= xa_r >> 1;
        xb_r  <= xb_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(PRICE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

`default_nettype wire

// ----- sv/act_sdiv.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
// expects num_hi < den so the quotient fits in PRICE_W bits
module act_sdiv import act_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  acc_t   num_hi,
  input  price_t num_lo,
  input  acc_t   den,
  output logic   done,
  output price_t quot
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  acc_t              rem_r;
  acc_t              den_r;
  price_t            q_r;
  logic [ACC_W:0]    trial;
  logic [ACC_W+1:0]  diff;
  logic              ge;

  assign trial = {rem_r, q_r[PRICE_W-1]};
  assign diff  = {1'b0, trial} - (ACC_W+2)'(den_r);
  assign ge    = !diff[ACC_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= num_hi;
        den_r  <= den;
        q_r    <= num_lo;
      end else if (busy_r) begin
        rem_r <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        q_r   <= {q_r[PRICE_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(PRICE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ----- sv/average_cost_position_tracker_core.sv -----
// Average-cost position tracker. Each input transfer is one trade fill (side, price Q24.8,
// quantity Q16.16, fee); each fill yields exactly one result transfer carrying the accepted
// flag, the saturated Q32.16 inventory, the Q24.8 average entry price, the Q40.24 profit
// realized by this fill and the running realized and fee totals. Fills with an invalid side,
// zero price or zero quantity are reported with accepted low and leave the state alone.
// One fill is processed at a time. A rejected fill or a fill from a flat position goes
// from evaluation straight to the output step; a reducing, closing or flipping fill first
// runs the bit-serial multiplier that forms closed quantity times price difference and
// then a realization step; a fill that adds to the position runs the serial multiply of
// both weighted terms and then the serial divide by the new size. The input is ready
// again the cycle after the result is loaded. The result sits in an output register, so
// the next fill may be taken while a result waits to be transferred; that next fill then
// holds in its last step until the waiting result leaves. The tracker state resets to zero.

`default_nettype none

module average_cost_position_tracker_core import act_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SIDE_W-1:0]  in_fill_side,
  input  logic [PRICE_W-1:0]        in_fill_price,
  input  logic [QTY_W-1:0]          in_fill_qty,
  input  logic signed [FEE_W-1:0]   in_fill_fee,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_accepted,
  output logic signed [POS_W-1:0]   out_inventory,
  output logic [PRICE_W-1:0]        out_entry_price,
  output logic signed [MONEY_W-1:0] out_fill_pnl,
  output logic signed [MONEY_W-1:0] out_realized_total,
  output logic signed [MONEY_W-1:0] out_fee_total
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_REAL,
    S_OUT
  } state_t;

  function automatic logic signed [MONEY_W-1:0] sat_add(
    input logic signed [MONEY_W-1:0] a,
    input logic signed [MONEY_W-1:0] b
  );
    logic signed [MONEY_W-1:0] s;
    s = a + b;
    if (!a[MONEY_W-1] && !b[MONEY_W-1] && s[MONEY_W-1]) return MONEY_MAX;
    if (a[MONEY_W-1] && b[MONEY_W-1] && !s[MONEY_W-1]) return MONEY_MIN;
    return s;
  endfunction

  state_t state_r;

  // captured fill
  logic [SIDE_W-1:0]         side_r;
  price_t                    price_r;
  logic [QTY_W-1:0]          qty_r;
  logic signed [FEE_W-1:0]   fee_r;

  // tracker state
  logic signed [POS_W-1:0]   pos_r;
  price_t                    avg_r;
  logic signed [MONEY_W-1:0] real_r;
  logic signed [MONEY_W-1:0] fees_r;

  // per-fill working flags
  logic                      ok_r;
  logic                      add_r;
  logic                      long_r;
  logic                      up_r;
  logic                      flip_r;
  logic                      exact_r;
  acc_t                      den_r;
  logic signed [MONEY_W-1:0] delta_r;

  // result register
  logic                      out_valid_r;
  logic                      out_accepted_r;
  logic signed [POS_W-1:0]   out_inventory_r;
  price_t                    out_entry_price_r;
  logic signed [MONEY_W-1:0] out_fill_pnl_r;
  logic signed [MONEY_W-1:0] out_realized_total_r;
  logic signed [MONEY_W-1:0] out_fee_total_r;

  // fill classification
  logic                      fill_ok;
  logic                      is_buy;
  logic                      pos_zero;
  logic                      pos_long;
  logic                      is_add;
  logic [POS_W-1:0]          pos_u;
  logic [POS_W-1:0]          mag;
  logic [POS_W-1:0]          qty_ext;
  logic [POS_W:0]            inv_sum;
  logic signed [POS_W-1:0]   pos_nxt;
  logic                      qty_lt_mag;
  logic                      qty_eq_mag;
  logic [QTY_W-1:0]          closed_lot;
  logic                      price_up;
  price_t                    price_diff;
  acc_t                      den_nxt;
  logic signed [MONEY_W-1:0] fee_ext;
  logic signed [MONEY_W-1:0] fees_nxt;

  // realization
  logic [MONEY_W-1:0]        prod64;
  logic                      delta_neg;
  logic signed [MONEY_W-1:0] delta_nxt;
  logic signed [MONEY_W-1:0] realized_nxt;

  // serial units
  logic                      mac_start;
  logic [POS_W-1:0]          mac_mcand_a;
  price_t                    mac_mplier_a;
  logic [QTY_W-1:0]          mac_mcand_b;
  price_t                    mac_mplier_b;
  logic                      mac_done;
  acc_t                      mac_hi;
  price_t                    mac_lo;
  logic                      div_start;
  logic                      div_done;
  price_t                    div_quot;

  assign fill_ok  = (side_r == SIDE_BUY || side_r == SIDE_SELL)
                 && price_r != '0 && qty_r != '0;
  assign is_buy   = (side_r == SIDE_BUY);
  assign pos_zero = (pos_r == '0);
  assign pos_long = !pos_r[POS_W-1] && !pos_zero;
  // adding to the position when the fill goes the same way as the inventory
  assign is_add   = !pos_zero && (pos_long == is_buy);

  assign pos_u   = pos_r;
  assign mag     = pos_r[POS_W-1] ? (~pos_u + 1'b1) : pos_u;
  assign qty_ext = POS_W'(qty_r);

  // new inventory, saturating at the signed limits
  assign inv_sum = is_buy ? ({pos_r[POS_W-1], pos_u} + {1'b0, qty_ext})
                          : ({pos_r[POS_W-1], pos_u} - {1'b0, qty_ext});
  assign pos_nxt = (inv_sum[POS_W] != inv_sum[POS_W-1])
                 ? (inv_sum[POS_W] ? POS_MIN : POS_MAX)
                 : inv_sum[POS_W-1:0];

  assign qty_lt_mag = qty_ext < mag;
  assign qty_eq_mag = qty_ext == mag;
  // closed amount never exceeds the fill quantity
  assign closed_lot = qty_lt_mag ? qty_r : mag[QTY_W-1:0];

  assign price_up   = price_r >= avg_r;
  assign price_diff = price_up ? (price_r - avg_r) : (avg_r - price_r);

  assign den_nxt  = ACC_W'(mag) + ACC_W'(qty_r);
  assign fee_ext  = {{(MONEY_W-FEE_W){fee_r[FEE_W-1]}}, fee_r};
  assign fees_nxt = sat_add(fees_r, fee_ext);

  // add: mag*avg + qty*price; reduce: close*|price - avg|
  assign mac_start    = (state_r == S_EVAL) && fill_ok && !pos_zero;
  assign mac_mcand_a  = is_add ? mag : POS_W'(closed_lot);
  assign mac_mplier_a = is_add ? avg_r : price_diff;
  assign mac_mcand_b  = is_add ? qty_r : '0;
  assign mac_mplier_b = is_add ? price_r : '0;

  act_smac u_smac (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mac_start),
    .mcand_a  (mac_mcand_a),
    .mplier_a (mac_mplier_a),
    .mcand_b  (mac_mcand_b),
    .mplier_b (mac_mplier_b),
    .done     (mac_done),
    .prod_hi  (mac_hi),
    .prod_lo  (mac_lo)
  );

  // weighted average: the numerator high part is always below the new size
  assign div_start = (state_r == S_MUL) && mac_done && add_r;

  act_sdiv u_sdiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num_hi (mac_hi),
    .num_lo (mac_lo),
    .den    (den_r),
    .done   (div_done),
    .quot   (div_quot)
  );

  // realized profit is negative for a long sold lower or a short bought higher
  assign prod64    = {mac_hi[MONEY_W-PRICE_W-1:0], mac_lo};
  assign delta_neg = long_r ? !up_r : up_r;
  always_comb begin
    if (prod64[MONEY_W-1]) begin
      delta_nxt = delta_neg ? MONEY_MIN : MONEY_MAX;
    end else if (delta_neg) begin
      delta_nxt = ~prod64 + 1'b1;
    end else begin
      delta_nxt = prod64;
    end
  end
  assign realized_nxt = sat_add(real_r, delta_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      avg_r       <= '0;
      real_r      <= '0;
      fees_r      <= '0;
    end else begin
      // in S_OUT a leaving result is replaced by the next one below
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            side_r  <= in_fill_side;
            price_r <= in_fill_price;
            qty_r   <= in_fill_qty;
            fee_r   <= in_fill_fee;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          ok_r    <= fill_ok;
          delta_r <= '0;
          add_r   <= is_add;
          long_r  <= pos_long;
          up_r    <= price_up;
          flip_r  <= !qty_lt_mag && !qty_eq_mag;
          exact_r <= qty_eq_mag;
          den_r   <= den_nxt;
          if (!fill_ok) begin
            state_r <= S_OUT;
          end else begin
            pos_r  <= pos_nxt;
            fees_r <= fees_nxt;
            if (pos_zero) begin
              // opening from flat
              avg_r   <= price_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mac_done) begin
            state_r <= add_r ? S_DIV : S_REAL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg_r   <= div_quot;
            state_r <= S_OUT;
          end
        end
        S_REAL: begin
          delta_r <= delta_nxt;
          real_r  <= realized_nxt;
          if (flip_r) begin
            avg_r <= price_r;
          end else if (exact_r) begin
            avg_r <= '0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait for the result register to free up
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_accepted_r       <= ok_r;
            out_inventory_r      <= pos_r;
            out_entry_price_r    <= avg_r;
            out_fill_pnl_r       <= delta_r;
            out_realized_total_r <= real_r;
            out_fee_total_r      <= fees_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_inventory      = out_inventory_r;
  assign out_entry_price    = out_entry_price_r;
  assign out_fill_pnl       = out_fill_pnl_r;
  assign out_realized_total = out_realized_total_r;
  assign out_fee_total      = out_fee_total_r;

endmodule

`default_nettype wire

// ----- sv/act_checker.sv -----
`default_nettype none

module act_checker import act_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [SIDE_W-1:0]  in_fill_side,
  input logic [PRICE_W-1:0]        in_fill_price,
  input logic [QTY_W-1:0]          in_fill_qty,
  input logic signed [FEE_W-1:0]   in_fill_fee,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_accepted,
  input logic signed [POS_W-1:0]   out_inventory,
  input logic [PRICE_W-1:0]        out_entry_price,
  input logic signed [MONEY_W-1:0] out_fill_pnl,
  input logic signed [MONEY_W-1:0] out_realized_total,
  input logic signed [MONEY_W-1:0] out_fee_total
);

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inventory)
      && $stable(out_realized_total) && $stable(out_fee_total))
    else $error("result changed while stalled");

  // one fill at a time: no transfer right after a transfer
  a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a fill is in progress");

  // a rejected fill realizes nothing
  a_reject_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_fill_pnl == '0)
    else $error("rejected fill reports realized profit");

  // entry price is cleared exactly when the position is flat
  a_flat_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_inventory == '0) == (out_entry_price == '0)))
    else $error("entry price and flat position disagree");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind average_cost_position_tracker_core act_checker u_act_checker (.*);

`default_nettype wire

// ----- verif/position_book_checker.sv -----
`default_nettype none

module position_book_checker import act_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [SIDE_W-1:0]  in_fill_side,
  input  logic [PRICE_W-1:0]        in_fill_price,
  input  logic [QTY_W-1:0]          in_fill_qty,
  input  logic signed [FEE_W-1:0]   in_fill_fee,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_accepted,
  input  logic signed [POS_W-1:0]   out_inventory,
  input  logic [PRICE_W-1:0]        out_entry_price,
  input  logic signed [MONEY_W-1:0] out_fill_pnl,
  input  logic signed [MONEY_W-1:0] out_realized_total,
  input  logic signed [MONEY_W-1:0] out_fee_total,
  output int                        mismatches,
  output int                        awaiting,
  output int                        results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      accepted;
    logic signed [POS_W-1:0]   inventory;
    logic [PRICE_W-1:0]        entry_price;
    logic signed [MONEY_W-1:0] fill_pnl;
    logic signed [MONEY_W-1:0] realized_total;
    logic signed [MONEY_W-1:0] fee_total;
  } fill_result_t;

  // book as the block should hold it
  logic signed [POS_W-1:0]   book_pos;
  logic [PRICE_W-1:0]        book_entry;
  logic signed [MONEY_W-1:0] book_realized;
  logic signed [MONEY_W-1:0] book_fee;

  fill_result_t pending_fill_results[$];

  function automatic logic signed [MONEY_W-1:0] money_sat_add(
      input logic signed [MONEY_W-1:0] a, input logic signed [MONEY_W-1:0] b);
    logic signed [MONEY_W-1:0] s;
    s = a + b;
    if (!a[MONEY_W-1] && !b[MONEY_W-1] && s[MONEY_W-1]) return MONEY_MAX;
    if (a[MONEY_W-1] && b[MONEY_W-1] && !s[MONEY_W-1]) return MONEY_MIN;
    return s;
  endfunction

  // applies one fill to the book and returns the result it should produce
  function automatic fill_result_t book_fill(input logic [SIDE_W-1:0] side,
      input logic [PRICE_W-1:0] price, input logic [QTY_W-1:0] qty,
      input logic signed [FEE_W-1:0] fee);
    fill_result_t r;
    logic ok, buy, loss;
    logic signed [63:0] pos_wide, moved, fee_wide;
    logic [63:0] mag, lot, gap, gain;
    logic [127:0] weighted;
    logic signed [POS_W-1:0] next_pos;
    logic [PRICE_W-1:0] next_entry;
    logic signed [MONEY_W-1:0] delta;
    ok = (side == SIDE_BUY || side == SIDE_SELL) && price != 0 && qty != 0;
    delta = '0;
    if (ok) begin
      buy = (side == SIDE_BUY);
      pos_wide = book_pos;
      fee_wide = fee;
      if (pos_wide < 0) mag = -pos_wide;
      else mag = pos_wide;
      moved = buy ? pos_wide + $signed({32'd0, qty}) : pos_wide - $signed({32'd0, qty});
      if (moved > POS_MAX) next_pos = POS_MAX;
      else if (moved < POS_MIN) next_pos = POS_MIN;
      else next_pos = moved[POS_W-1:0];
      next_entry = book_entry;
      if (pos_wide == 0) begin
        next_entry = price;
      end else if ((pos_wide > 0) == buy) begin
        // weighted average over the unsaturated new size, truncated
        weighted = 128'(mag) * 128'(book_entry) + 128'(qty) * 128'(price);
        next_entry = PRICE_W'(weighted / 128'(mag + 64'(qty)));
      end else begin
        lot  = (64'(qty) < mag) ? 64'(qty) : mag;
        gap  = (price >= book_entry) ? 64'(price - book_entry) : 64'(book_entry - price);
        gain = lot * gap;
        loss = (pos_wide > 0) ? (price < book_entry) : (price >= book_entry);
        if (loss) delta = gain[63] ? MONEY_MIN : -$signed(gain);
        else delta = gain[63] ? MONEY_MAX : $signed(gain);
        book_realized = money_sat_add(book_realized, delta);
        if (64'(qty) > mag) next_entry = price;
        else if (next_pos == 0) next_entry = '0;
      end
      book_fee   = money_sat_add(book_fee, fee_wide);
      book_pos   = next_pos;
      book_entry = next_entry;
    end
    r.accepted       = ok;
    r.inventory      = book_pos;
    r.entry_price    = book_entry;
    r.fill_pnl       = delta;
    r.realized_total = book_realized;
    r.fee_total      = book_fee;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("result %0d: %s got %h, expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    fill_result_t want;
    if (!rst_n) begin
      book_pos      = '0;
      book_entry    = '0;
      book_realized = '0;
      book_fee      = '0;
      pending_fill_results.delete();
      mismatches    = 0;
      results_seen  = 0;
      awaiting <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_fill_results.size() == 0) begin
          flag_mismatch("result with no fill outstanding", '0, '0);
        end else begin
          want = pending_fill_results.pop_front();
          if (out_accepted !== want.accepted)
            flag_mismatch("accepted", out_accepted, want.accepted);
          if (out_inventory !== want.inventory)
            flag_mismatch("inventory", out_inventory, want.inventory);
          if (out_entry_price !== want.entry_price)
            flag_mismatch("entry_price", out_entry_price, want.entry_price);
          if (out_fill_pnl !== want.fill_pnl)
            flag_mismatch("fill_pnl", out_fill_pnl, want.fill_pnl);
          if (out_realized_total !== want.realized_total)
            flag_mismatch("realized_total", out_realized_total, want.realized_total);
          if (out_fee_total !== want.fee_total)
            flag_mismatch("fee_total", out_fee_total, want.fee_total);
        end
      end
      if (in_valid && in_ready)
        pending_fill_results.push_back(
            book_fill(in_fill_side, in_fill_price, in_fill_qty, in_fill_fee));
      awaiting <= pending_fill_results.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/average_cost_position_tracker_core_tb.sv -----
`default_nettype none

module average_cost_position_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import act_pkg::*;

  // run limit, with headroom over the slowest run
  localparam int RUN_LIMIT       = 1_000_000;
  localparam int LONG_STALL      = 400;
  localparam int SETTLE_CYCLES   = 100;
  localparam int FILLS_PER_PHASE = 570;

  // side patterns the block must refuse
  localparam logic [SIDE_W-1:0] SIDE_NONE = 2'b00;
  localparam logic [SIDE_W-1:0] SIDE_BAD  = 2'b10;

  localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
  localparam logic [QTY_W-1:0]   QTY_TOP   = '1;
  localparam logic [FEE_W-1:0]   FEE_TOP   = {1'b0, {(FEE_W-1){1'b1}}};
  localparam logic [FEE_W-1:0]   FEE_BOT   = {1'b1, {(FEE_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SIDE_W-1:0]  in_fill_side = '0;
  logic [PRICE_W-1:0]        in_fill_price = '0;
  logic [QTY_W-1:0]          in_fill_qty = '0;
  logic signed [FEE_W-1:0]   in_fill_fee = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      out_accepted;
  logic signed [POS_W-1:0]   out_inventory;
  logic [PRICE_W-1:0]        out_entry_price;
  logic signed [MONEY_W-1:0] out_fill_pnl;
  logic signed [MONEY_W-1:0] out_realized_total;
  logic signed [MONEY_W-1:0] out_fee_total;

  int mismatches, awaiting, results_seen;

  // pacing knobs, percent of cycles spent idle
  int send_idle_pct = 34;
  int recv_idle_pct = 55;
  logic hold_req = 1'b0;
  int cycles = 0;

  // rough position seen by the sender, only to shape stimulus
  longint shadow_pos = 0;
  int n_valid = 0, n_open = 0, n_add = 0, n_reduce = 0, n_close = 0, n_flip = 0;
  int n_reject = 0;

  always #5 clk = ~clk;

  average_cost_position_tracker_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_fill_side       (in_fill_side),
    .in_fill_price      (in_fill_price),
    .in_fill_qty        (in_fill_qty),
    .in_fill_fee        (in_fill_fee),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_inventory      (out_inventory),
    .out_entry_price    (out_entry_price),
    .out_fill_pnl       (out_fill_pnl),
    .out_realized_total (out_realized_total),
    .out_fee_total      (out_fee_total)
  );

  position_book_checker book_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_fill_side       (in_fill_side),
    .in_fill_price      (in_fill_price),
    .in_fill_qty        (in_fill_qty),
    .in_fill_fee        (in_fill_fee),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_inventory      (out_inventory),
    .out_entry_price    (out_entry_price),
    .out_fill_pnl       (out_fill_pnl),
    .out_realized_total (out_realized_total),
    .out_fee_total      (out_fee_total),
    .mismatches         (mismatches),
    .awaiting           (awaiting),
    .results_seen       (results_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, awaiting);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin : output_pacing
    int stall_left;
    bit hold_served;
    stall_left  = 0;
    hold_served = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_served) begin
        // long hold so the block fills its output register and stalls the input
        hold_served = 1'b1;
        stall_left  = LONG_STALL - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  // one fill transfer, with random idle cycles in front of it
  task automatic send_fill(input logic [SIDE_W-1:0] side, input logic [PRICE_W-1:0] price,
                           input logic [QTY_W-1:0] qty, input logic [FEE_W-1:0] fee);
    longint mag;
    logic buy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_fill_side  <= side;
    in_fill_price <= price;
    in_fill_qty   <= qty;
    in_fill_fee   <= fee;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // tally what kind of fill this was against the position it met
    mag = (shadow_pos < 0) ? -shadow_pos : shadow_pos;
    buy = (side == SIDE_BUY);
    if (!((side == SIDE_BUY || side == SIDE_SELL) && price != 0 && qty != 0)) begin
      n_reject++;
    end else begin
      n_valid++;
      if (shadow_pos == 0) n_open++;
      else if ((shadow_pos > 0) == buy) n_add++;
      else if (qty < mag) n_reduce++;
      else if (qty == mag) n_close++;
      else n_flip++;
      shadow_pos = buy ? shadow_pos + qty : shadow_pos - qty;
    end
  endtask

  // stop offering fills until every result is back, then let the block settle
  task automatic drain_book();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaiting == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int target, roll;
    longint mag;
    logic [SIDE_W-1:0]  side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [FEE_W-1:0]   fee;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // refused fills: bad side patterns, zero price, zero quantity
    send_fill(SIDE_NONE, 32'h6400, 32'h1_0000, 48'h100);
    send_fill(SIDE_BAD,  32'h6400, 32'h1_0000, 48'h100);
    send_fill(SIDE_BUY,  32'h0,    32'h1_0000, 48'h100);
    send_fill(SIDE_SELL, 32'h6400, 32'h0,      48'h100);
    // long side: open at top price, add at bottom price, trim, close exactly
    send_fill(SIDE_BUY,  PRICE_TOP, 32'h1,       FEE_TOP);
    send_fill(SIDE_BUY,  32'h1,     QTY_TOP,     FEE_BOT);
    send_fill(SIDE_SELL, 32'h100,   32'h1_0000,  48'h0);
    send_fill(SIDE_SELL, 32'h80,    32'hFFFF_0000, 48'hFFFF_FFFF_FF00);
    // short side: open, add, trim, flip long, flip short, close at entry
    send_fill(SIDE_SELL, 32'h5000, 32'h3_0000, 48'h40);
    send_fill(SIDE_SELL, 32'h6000, 32'h1_0000, 48'h40);
    send_fill(SIDE_BUY,  32'h4000, 32'h8000,   48'h40);
    send_fill(SIDE_BUY,  32'h7000, 32'h8_0000, 48'h40);
    send_fill(SIDE_SELL, 32'h6800, 32'h5_0000, 48'h40);
    send_fill(SIDE_BUY,  32'h6800, 32'h8000,   48'h40);
    // huge losses push the per-fill delta and then the total to the low rail
    repeat (2) begin
      send_fill(SIDE_BUY,  PRICE_TOP, QTY_TOP, 48'h0);
      send_fill(SIDE_SELL, 32'h1,     QTY_TOP, 48'h0);
    end
    // huge wins climb back and pin the total at the high rail
    repeat (3) begin
      send_fill(SIDE_BUY,  32'h1,     QTY_TOP, 48'h0);
      send_fill(SIDE_SELL, PRICE_TOP, QTY_TOP, 48'h0);
    end
    drain_book();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct <= 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      target = n_valid + FILLS_PER_PHASE;
      while (n_valid < target) begin
        if (phase == 0 && n_valid == target - FILLS_PER_PHASE / 2) hold_req <= 1'b1;

        case ($urandom_range(19))
          0:       price = $urandom_range(32'hFFFF_FFFF, 1);
          1:       price = $urandom_range(1) ? PRICE_TOP : 32'h1;
          2, 3:    price = $urandom_range(32'h00FF_FFFF, 1);
          default: price = 32'h5C00 + $urandom_range(32'h1000);
        endcase
        case ($urandom_range(19))
          0:       qty = $urandom_range(32'hFFFF_FFFF, 1);
          1, 2, 3: qty = $urandom_range(32'h00FF_FFFF, 1);
          default: qty = $urandom_range(32'h0004_0000, 1);
        endcase
        if ($urandom_range(3) == 0) fee = FEE_W'({$urandom, $urandom});
        else fee = FEE_W'($signed(25'($urandom)));

        mag  = (shadow_pos < 0) ? -shadow_pos : shadow_pos;
        side = $urandom_range(1) ? SIDE_BUY : SIDE_SELL;
        roll = $urandom_range(99);
        if (roll < 8) begin
          // broken fill: one thing wrong, the rest plausible
          case ($urandom_range(3))
            0:       side = SIDE_NONE;
            1:       side = SIDE_BAD;
            2:       price = '0;
            default: qty = '0;
          endcase
        end else if (roll < 45 || shadow_pos == 0) begin
          // open from flat or add on the same side
          if (shadow_pos != 0) side = (shadow_pos > 0) ? SIDE_BUY : SIDE_SELL;
        end else if (roll < 93) begin
          side = (shadow_pos > 0) ? SIDE_SELL : SIDE_BUY;
          if (mag > 64'hFFFF_FFFF)
            qty = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);  // walk a big book down
          else if (roll < 67 && mag > 1)
            qty = $urandom_range(32'(mag - 1), 1);
          else if (roll < 80 || mag >= 64'hFFF0_0000)
            qty = 32'(mag);
          else
            qty = 32'(mag) + $urandom_range(32'h4_0000, 1);
        end else begin
          // anything goes, zeros included
          side = SIDE_W'($urandom);
          if ($urandom_range(9) == 0) price = '0;
          if ($urandom_range(9) == 0) qty = '0;
        end
        send_fill(side, price, qty, fee);
      end
      drain_book();
    end

    $display("%0d valid fills (%0d opens, %0d adds, %0d trims, %0d exact closes,",
             n_valid, n_open, n_add, n_reduce, n_close);
    $display("%0d flips), %0d refused; %0d results checked over three pacing mixes",
             n_flip, n_reject, results_seen);
    $display("and one long output hold-off");
    if (mismatches == 0 && awaiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
